[sv/weighted_histogram_cumulative_top_macros.svh]
// Assertion macros shared by the checker of the weighted histogram block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef WEIGHTED_HISTOGRAM_CUMULATIVE_TOP_MACROS_SVH
`define WEIGHTED_HISTOGRAM_CUMULATIVE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define WHCUM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("whcum assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define WHCUM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("whcum assertion failed");

`endif

[sv/whcum_pkg.sv]
// Package for the weighted histogram block: item types, command codes,
// controller states and register map. No dependencies.
package whcum_pkg;

	// Field widths of the item types
	localparam int VALUE_BITS   = 16;
	localparam int WEIGHT_BITS  = 16;
	localparam int CNT_OUT_BITS = 50;
	localparam int KEPT_BITS    = 17;

	// Configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	typedef logic [APB_ADDR_BITS-3:0] reg_idx_t;
	localparam reg_idx_t REG_MAX_VALUE = '0;
	localparam logic [VALUE_BITS-1:0] MAX_VALUE_RESET = 16'd255;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_IGNORE = 2'd1,
		CMD_ADD    = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_POST
	} state_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [VALUE_BITS-1:0]  value;
		logic [WEIGHT_BITS-1:0] weight;
	} req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]   bin_value;
		logic [CNT_OUT_BITS-1:0] bin_count;
		logic [CNT_OUT_BITS-1:0] below_sum;
		logic [CNT_OUT_BITS-1:0] above_sum;
		logic [KEPT_BITS-1:0]    below_kept;
		logic [KEPT_BITS-1:0]    above_kept;
		logic [CNT_OUT_BITS-1:0] grand_total;
		logic [KEPT_BITS-1:0]    kept_values;
		logic                    is_ignored;
		logic                    overflowed;
		logic                    last;
	} rsp_t;

endpackage

[sv/whcum_regs.sv]
// APB-style configuration register bank of the weighted histogram block.
// Holds max_value. Depends on whcum_pkg.
module whcum_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [whcum_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [whcum_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [whcum_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                   pready,
	output logic [whcum_pkg::VALUE_BITS-1:0]       max_value
);

	whcum_pkg::reg_idx_t              reg_idx;
	logic                             wr_en;
	logic [whcum_pkg::VALUE_BITS-1:0] max_value_q;

	// Word address decode
	assign reg_idx = paddr[whcum_pkg::APB_ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= whcum_pkg::MAX_VALUE_RESET;
		end else if (wr_en && (reg_idx == whcum_pkg::REG_MAX_VALUE)) begin
			max_value_q <= pwdata[whcum_pkg::VALUE_BITS-1:0];
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			whcum_pkg::REG_MAX_VALUE: begin
				prdata = whcum_pkg::APB_DATA_BITS'(max_value_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign max_value = max_value_q;

endmodule

[sv/weighted_histogram_cumulative_top.sv]
// Top level of the weighted histogram block with cumulative readout.
// Depends on whcum_pkg and whcum_regs; bin store is a local one-port memory.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   whcum_pkg::req_t (cmd, value, weight)
//   rsp       out        rsp_valid / rsp_ready   whcum_pkg::rsp_t (one item per read cmd)
//   apb       in         psel / penable / pready max_value at byte address 0
//
// Ignore and add: accept with memory read, then write back in the execute state.
// Read goes through read, subtract and result load; the result register is the limit
// when the downstream side stalls, and req is accepted while a result waits there.
// Reset and the clear command sweep all 2^SAMPLE_BITS bins, one per cycle, with
// req_ready low; configuration writes are taken during the sweep.
module weighted_histogram_cumulative_top #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 50
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [whcum_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [whcum_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [whcum_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                pready,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  whcum_pkg::req_t                     req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output whcum_pkg::rsp_t                     rsp
);

	localparam int DEPTH = 1 << SAMPLE_BITS;
	localparam int MEM_W = COUNT_BITS + 1;
	localparam int VAL_W = whcum_pkg::VALUE_BITS;
	localparam int OUT_W = whcum_pkg::CNT_OUT_BITS;
	localparam int KPT_W = whcum_pkg::KEPT_BITS;
	localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(DEPTH - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Configuration
	logic [VAL_W-1:0]       max_value;
	logic [SAMPLE_BITS-1:0] eff_max;

	// Controller
	whcum_pkg::state_t state_q, state_d;
	logic              accept;
	logic              rsp_load;
	logic              clr_done;
	logic [SAMPLE_BITS-1:0] clr_addr_q;

	// Item registers
	whcum_pkg::cmd_t        cmd_q;
	logic [SAMPLE_BITS-1:0] addr_q;
	logic [whcum_pkg::WEIGHT_BITS-1:0] weight_q;
	logic                   in_range_q;

	// Scalar state
	logic [COUNT_BITS-1:0]  total_q;
	logic [KPT_W-1:0]       ign_cnt_q;
	logic [SAMPLE_BITS-1:0] rptr_q;
	logic [COUNT_BITS-1:0]  rsum_q;
	logic [KPT_W-1:0]       rkept_q;
	logic                   ovf_q;

	// Bin memory: {ignore mark, count}
	logic [MEM_W-1:0]       bin_mem [DEPTH];
	logic [MEM_W-1:0]       mem_rd_q;
	logic                   mem_re;
	logic                   mem_we;
	logic [SAMPLE_BITS-1:0] mem_raddr;
	logic [SAMPLE_BITS-1:0] mem_waddr;
	logic [MEM_W-1:0]       mem_wdata;

	// Read-modify-write datapath
	logic                   ptr_wrap;
	logic [SAMPLE_BITS-1:0] rd_ptr;
	logic                   rd_ign;
	logic [COUNT_BITS-1:0]  rd_cnt;
	logic                   do_update;
	logic [MEM_W-1:0]       bin_sum;
	logic [MEM_W-1:0]       tot_sum;
	logic [COUNT_BITS-1:0]  bin_new;
	logic [COUNT_BITS-1:0]  tot_new;

	// Readout datapath
	logic [COUNT_BITS-1:0]  bin_cnt_q;
	logic                   bin_ign_q;
	logic [MEM_W-1:0]       diff_q;
	logic [MEM_W-1:0]       above_diff;
	logic [COUNT_BITS-1:0]  above;
	logic [KPT_W-1:0]       range_cnt;
	logic [KPT_W-1:0]       kept;
	logic                   self_k;
	logic [KPT_W:0]         kept_diff;
	logic [KPT_W-1:0]       above_k;
	logic                   is_last;
	logic [MEM_W-1:0]       rsum_sum;
	logic [COUNT_BITS-1:0]  rsum_new;
	whcum_pkg::rsp_t        rsp_d;
	whcum_pkg::rsp_t        rsp_q;
	logic                   rsp_valid_q;

	whcum_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_value (max_value)
	);

	// Largest bin in use, capped at the last bin of the store
	assign eff_max = (max_value > VAL_MAX) ? VAL_MAX[SAMPLE_BITS-1:0]
	                                       : max_value[SAMPLE_BITS-1:0];

	// Controller outputs
	always_comb begin
		req_ready = (state_q == whcum_pkg::ST_IDLE);
		rsp_load  = (state_q == whcum_pkg::ST_POST) && (!rsp_valid_q || rsp_ready);
		clr_done  = (state_q == whcum_pkg::ST_CLEAR) && (clr_addr_q == '1);
	end

	assign accept = req_valid && req_ready;

	// Controller next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			whcum_pkg::ST_CLEAR: begin
				if (clr_done) state_d = whcum_pkg::ST_IDLE;
			end
			whcum_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.cmd == whcum_pkg::CMD_CLEAR) ? whcum_pkg::ST_CLEAR
					                                            : whcum_pkg::ST_EXEC;
				end
			end
			whcum_pkg::ST_EXEC: begin
				state_d = (cmd_q == whcum_pkg::CMD_READ) ? whcum_pkg::ST_POST
				                                         : whcum_pkg::ST_IDLE;
			end
			whcum_pkg::ST_POST: begin
				if (rsp_load) state_d = whcum_pkg::ST_IDLE;
			end
			default: begin
				state_d = whcum_pkg::ST_CLEAR;
			end
		endcase
	end

	// Read address: sample value, or readout position (wrapped when beyond range)
	assign ptr_wrap  = VAL_W'(rptr_q) > VAL_W'(eff_max);
	assign rd_ptr    = ptr_wrap ? '0 : rptr_q;
	assign mem_re    = accept && (req.cmd != whcum_pkg::CMD_CLEAR);
	assign mem_raddr = (req.cmd == whcum_pkg::CMD_READ) ? rd_ptr
	                                                    : req.value[SAMPLE_BITS-1:0];

	// Saturating updates of the bin and the total
	assign rd_ign    = mem_rd_q[COUNT_BITS];
	assign rd_cnt    = mem_rd_q[COUNT_BITS-1:0];
	assign do_update = in_range_q && !rd_ign;
	assign bin_sum   = {1'b0, rd_cnt} + MEM_W'(weight_q);
	assign tot_sum   = {1'b0, total_q} + MEM_W'(weight_q);
	assign bin_new   = bin_sum[COUNT_BITS] ? COUNT_MAX : bin_sum[COUNT_BITS-1:0];
	assign tot_new   = tot_sum[COUNT_BITS] ? COUNT_MAX : tot_sum[COUNT_BITS-1:0];

	// Write port: clearing sweep or write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (state_q == whcum_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
		end else if (state_q == whcum_pkg::ST_EXEC) begin
			case (cmd_q)
				whcum_pkg::CMD_IGNORE: begin
					mem_we    = do_update;
					mem_wdata = {1'b1, rd_cnt};
				end
				whcum_pkg::CMD_ADD: begin
					mem_we    = do_update;
					mem_wdata = {1'b0, bin_new};
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rd_q <= bin_mem[mem_raddr];
	end

	// Readout: floored differences against the running sums
	assign above_diff = {1'b0, diff_q[COUNT_BITS-1:0]} - {1'b0, bin_cnt_q};
	assign above      = (diff_q[COUNT_BITS] || above_diff[COUNT_BITS]) ? '0
	                                                                   : above_diff[COUNT_BITS-1:0];
	assign range_cnt  = KPT_W'(eff_max) + KPT_W'(1);
	assign kept       = (range_cnt > ign_cnt_q) ? (range_cnt - ign_cnt_q) : '0;
	assign self_k     = !bin_ign_q;
	assign kept_diff  = {1'b0, kept} - {1'b0, rkept_q};
	assign above_k    = (kept_diff[KPT_W] || (kept_diff[KPT_W-1:0] < KPT_W'(self_k))) ? '0
	                    : (kept_diff[KPT_W-1:0] - KPT_W'(self_k));
	assign is_last    = (addr_q == eff_max);
	assign rsum_sum   = {1'b0, rsum_q} + {1'b0, bin_cnt_q};
	assign rsum_new   = rsum_sum[COUNT_BITS] ? COUNT_MAX : rsum_sum[COUNT_BITS-1:0];

	always_comb begin
		rsp_d.bin_value   = VAL_W'(addr_q);
		rsp_d.bin_count   = OUT_W'(bin_cnt_q);
		rsp_d.below_sum   = OUT_W'(rsum_q);
		rsp_d.above_sum   = OUT_W'(above);
		rsp_d.below_kept  = rkept_q;
		rsp_d.above_kept  = above_k;
		rsp_d.grand_total = OUT_W'(total_q);
		rsp_d.kept_values = kept;
		rsp_d.is_ignored  = bin_ign_q;
		rsp_d.overflowed  = ovf_q;
		rsp_d.last        = is_last;
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= whcum_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			total_q     <= '0;
			ign_cnt_q   <= '0;
			rptr_q      <= '0;
			rsum_q      <= '0;
			rkept_q     <= '0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == whcum_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;

			if (accept) begin
				case (req.cmd)
					whcum_pkg::CMD_CLEAR: begin
						clr_addr_q <= '0;
						total_q    <= '0;
						ign_cnt_q  <= '0;
						rptr_q     <= '0;
						rsum_q     <= '0;
						rkept_q    <= '0;
						ovf_q      <= 1'b0;
					end
					whcum_pkg::CMD_READ: begin
						if (ptr_wrap) begin
							rptr_q  <= '0;
							rsum_q  <= '0;
							rkept_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end

			if ((state_q == whcum_pkg::ST_EXEC) && do_update) begin
				if (cmd_q == whcum_pkg::CMD_IGNORE) ign_cnt_q <= ign_cnt_q + KPT_W'(1);
				if (cmd_q == whcum_pkg::CMD_ADD) begin
					total_q <= tot_new;
					if (bin_sum[COUNT_BITS] || tot_sum[COUNT_BITS]) ovf_q <= 1'b1;
				end
			end

			// Advance or restart the readout
			if (rsp_load) begin
				if (is_last) begin
					rptr_q  <= '0;
					rsum_q  <= '0;
					rkept_q <= '0;
				end else begin
					rptr_q  <= addr_q + 1'b1;
					rsum_q  <= rsum_new;
					rkept_q <= rkept_q + KPT_W'(self_k);
				end
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item and readout payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= req.cmd;
			addr_q     <= mem_raddr;
			weight_q   <= req.weight;
			in_range_q <= VAL_W'(req.value[SAMPLE_BITS-1:0]) <= VAL_W'(eff_max);
		end
		if (state_q == whcum_pkg::ST_EXEC) begin
			bin_cnt_q <= rd_cnt;
			bin_ign_q <= rd_ign;
			diff_q    <= {1'b0, total_q} - {1'b0, rsum_q};
		end
		if (rsp_load) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/whcum_checker.sv]
// Port-level checker for the weighted histogram block, bound to its top level.
// Depends on whcum_pkg and weighted_histogram_cumulative_top_macros.svh.
`include "weighted_histogram_cumulative_top_macros.svh"

module whcum_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input whcum_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input whcum_pkg::rsp_t rsp
);

	logic req_fire;
	logic clr_fire;

	assign req_fire = req_valid && req_ready;
	assign clr_fire = req_fire && (req.cmd == whcum_pkg::CMD_CLEAR);

	// A stalled result item holds
	`WHCUM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// Every item occupies the bin memory before req_ready rises again
	`WHCUM_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ready)

	// A clear sweeps the memory before the next item
	`WHCUM_ASSERT_NEXT(a_clear_sweep, clr_fire, !req_ready ##1 !req_ready)

	// A new result is only loaded while the input side is busy
	`WHCUM_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), $past(!req_ready))

endmodule

bind weighted_histogram_cumulative_top whcum_checker u_whcum_checker (.*);
